FILE: rtl/core/bounded_deque_with_search_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque with search
// Shared macros for concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDQS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bdqs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bdqs check failed");

`endif

FILE: rtl/core/bdqs_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque with search package
// Depth, widths, operation and status codes, and shared types.
// ----------------------------------------------------------------------------
package bdqs_pkg;

    localparam int DEPTH     = 16;
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 5;
    localparam int MDATA_W   = 40;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_DELETE   = 3'd2,
        OP_SEARCH   = 3'd3,
        OP_COUNT    = 3'd4,
        OP_TRAVERSE = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DEL,
        S_SRCH,
        S_TRAV
    } state_t;

    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } ram_req_t;

    typedef struct packed {
        logic                 load;
        logic [STATUS_W-1:0]  status;
        logic [DATA_W-1:0]    item;
        logic                 found;
        logic [ENTRIES_W-1:0] entries;
        logic                 last;
    } result_t;

    function automatic logic [PTR_W-1:0] slot_addr(input logic [PTR_W-1:0] base,
                                                   input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W+1)'(DEPTH)) begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

FILE: rtl/core/bdqs_ram.sv
// ----------------------------------------------------------------------------
// Entry store
// One write port and one registered read port over the ring of entries.
// ----------------------------------------------------------------------------
module bdqs_ram
    import bdqs_pkg::*;
(
    input  logic              aclk,
    input  ram_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/bdqs_seq.sv
// ----------------------------------------------------------------------------
// Request sequencer
// Holds head and fill, walks the ring one entry a cycle for search and for
// traverse while the output is free, through slot_addr and a single equality compare.
// ----------------------------------------------------------------------------
module bdqs_seq
    import bdqs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [OP_W-1:0]   start_op,
    input  logic [DATA_W-1:0] start_value,
    input  logic              out_free,
    input  logic [DATA_W-1:0] rdata,
    output ram_req_t          ram_req,
    output result_t           res,
    output logic              idle
);

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] value_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [PTR_W-1:0]  idx_reg, idx_next;

    logic             is_full, is_empty, last_idx, hit;
    logic [PTR_W-1:0] head_dec, idx_inc;

    assign is_full  = (fill_reg >= CNT_W'(DEPTH));
    assign is_empty = (fill_reg == '0);
    assign last_idx = ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_reg);
    assign hit      = (rdata == value_reg);
    assign head_dec = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - PTR_W'(1);
    assign idx_inc  = idx_reg + PTR_W'(1);
    assign idle     = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg    <= start_op;
            value_reg <= start_value;
        end
    end

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        ram_req     = '0;
        res         = '0;
        res.status  = STAT_OK;
        res.entries = ENTRIES_W'(fill_reg);
        res.last    = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_IDLE;
                unique case (op_reg)
                    OP_APPEND: begin
                        res.load = 1'b1;
                        if (is_full) begin
                            res.status = STAT_FULL;
                        end else begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = slot_addr(head_reg, fill_reg[PTR_W-1:0]);
                            ram_req.wdata = value_reg;
                            fill_next     = fill_reg + CNT_W'(1);
                            res.entries   = ENTRIES_W'(fill_reg + CNT_W'(1));
                        end
                    end
                    OP_INSERT: begin
                        res.load = 1'b1;
                        if (is_full) begin
                            res.status = STAT_FULL;
                        end else begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = head_dec;
                            ram_req.wdata = value_reg;
                            head_next     = head_dec;
                            fill_next     = fill_reg + CNT_W'(1);
                            res.entries   = ENTRIES_W'(fill_reg + CNT_W'(1));
                        end
                    end
                    OP_DELETE, OP_SEARCH, OP_TRAVERSE: begin
                        if (is_empty) begin
                            res.load   = 1'b1;
                            res.status = STAT_EMPTY;
                        end else begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = head_reg;
                            idx_next      = '0;
                            priority if (op_reg == OP_DELETE) begin
                                state_next = S_DEL;
                            end else if (op_reg == OP_SEARCH) begin
                                state_next = S_SRCH;
                            end else begin
                                state_next = S_TRAV;
                            end
                        end
                    end
                    OP_COUNT: begin
                        res.load   = 1'b1;
                        res.status = is_empty ? STAT_EMPTY : STAT_OK;
                    end
                    default: begin
                        res.load = 1'b1;
                    end
                endcase
            end
            S_DEL: begin
                res.load    = 1'b1;
                res.item    = rdata;
                res.entries = ENTRIES_W'(fill_reg - CNT_W'(1));
                head_next   = slot_addr(head_reg, PTR_W'(1));
                fill_next   = fill_reg - CNT_W'(1);
                state_next  = S_IDLE;
            end
            S_SRCH: begin
                if (hit || last_idx) begin
                    res.load   = 1'b1;
                    res.found  = hit;
                    state_next = S_IDLE;
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = slot_addr(head_reg, idx_inc);
                    idx_next      = idx_inc;
                end
            end
            S_TRAV: begin
                if (out_free) begin
                    res.load = 1'b1;
                    res.item = rdata;
                    res.last = last_idx;
                    if (last_idx) begin
                        state_next = S_IDLE;
                    end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = slot_addr(head_reg, idx_inc);
                        idx_next      = idx_inc;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// Bounded deque with search
// A ring of up to DEPTH signed 32-bit entries with head and tail access,
// search, count and traverse.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel: s_tuser carries the operation and s_tdata
// the value. Results leave on the m_ channel with status in m_tuser and
// m_tlast set on the final result of each request.
// One request is handled at a time. An item is taken only while the block is
// idle and its output register is empty.
// Append, insert front, count and the empty cases load their result into the
// output register from the execute state. Delete first reads the head entry
// from the registered read port of the store before its result is loaded.
// Search reads one entry a cycle through the shared compare and finishes
// on the first match or once the last occupied entry has been compared.
// Traverse reads the head entry before its first result and then gives one
// result a cycle, up to DEPTH results, while the receiver keeps m_tready high.
// When the receiver stalls, the pending result holds in the output register
// and the walk pauses until it is taken.
// Reset empties the list at once; the store contents are not cleared, since
// only occupied entries are ever read.
// ----------------------------------------------------------------------------
module bounded_deque_with_search
    import bdqs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // value[31:0]
    input  logic [7:0]         s_tuser,   // op[2:0], zero[7:3]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata,   // item[31:0], found[32], entries[37:33], zero[39:38]
    output logic               m_tlast,
    output logic [7:0]         m_tuser    // status[1:0], zero[7:2]
);

    ram_req_t          ram_req;
    result_t           res;
    logic [DATA_W-1:0] rdata;
    logic              idle, start, out_free;

    logic                m_tvalid_reg;
    logic [MDATA_W-1:0]  m_tdata_reg;
    logic                m_tlast_reg;
    logic [STATUS_W-1:0] m_status_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = idle && !m_tvalid_reg;
    assign start    = s_tvalid && s_tready;

    bdqs_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .start_op    (s_tuser[OP_W-1:0]),
        .start_value (s_tdata),
        .out_free    (out_free),
        .rdata       (rdata),
        .ram_req     (ram_req),
        .res         (res),
        .idle        (idle)
    );

    bdqs_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.load) begin
            m_tdata_reg  <= {2'b00, res.entries, res.found, res.item};
            m_tlast_reg  <= res.last;
            m_status_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = {6'b000000, m_status_reg};

endmodule

FILE: rtl/core/bdqs_checker.sv
// ----------------------------------------------------------------------------
// Port checker for the bounded deque with search
// Watches the top-level ports and flags results that break the block rules.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_search_defines.svh"

module bdqs_checker
    import bdqs_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [MDATA_W-1:0] m_tdata,
    input logic               m_tlast,
    input logic [7:0]         m_tuser
);

    logic [MDATA_W+8:0]   m_beat;
    logic [ENTRIES_W-1:0] m_entries;
    logic [STATUS_W-1:0]  m_status;
    logic                 m_found;
    logic                 out_stall;
    logic                 empty_out;
    logic                 zero_fields;

    assign m_beat      = {m_tdata, m_tlast, m_tuser};
    assign m_entries   = m_tdata[37:33];
    assign m_found     = m_tdata[32];
    assign m_status    = m_tuser[STATUS_W-1:0];
    assign out_stall   = m_tvalid && !m_tready;
    assign empty_out   = m_tvalid && (m_status == STAT_EMPTY);
    assign zero_fields = !m_found && (m_entries == '0);

    `BDQS_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(m_beat))
    `BDQS_ASSERT_IMPL(a_ready_needs_empty_out, aclk, aresetn, s_tready, !m_tvalid)
    `BDQS_ASSERT_IMPL(a_entries_bound, aclk, aresetn, m_tvalid, m_entries <= ENTRIES_W'(DEPTH))
    `BDQS_ASSERT_IMPL(a_empty_single, aclk, aresetn, empty_out, m_tlast && zero_fields)

endmodule

bind bounded_deque_with_search bdqs_checker u_bdqs_checker (.*);
